@@ rtl/wgm_pkg.sv @@
// ----------------------------------------------------------------------------
// wgm_pkg - shared definitions for the wildcard glob matcher
// Commands, wildcard byte codes, pattern capacity and cell control word.
// ----------------------------------------------------------------------------
package wgm_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

  localparam logic [7:0] CHAR_ANY_ONE = 8'h3F;  // '?'
  localparam logic [7:0] CHAR_ANY_RUN = 8'h2A;  // '*'

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic       clear;      // empty the pattern
    logic       restart;    // reseed the active set at position zero
    logic       step;       // consume text_char
    logic [7:0] text_char;
  } cell_ctl_t;

  // Result word: matched in bit 0, pattern_overflow in bit 1.
  typedef struct packed {
    logic pattern_overflow;
    logic matched;
  } result_t;

endpackage

@@ rtl/wgm_cell.sv @@
// ----------------------------------------------------------------------------
// wgm_cell - one pattern position of the matcher chain
// Holds one pattern byte, its valid bit and the raw active bit of its
// position; closes over '*' and advances the active set toward its neighbor.
// ----------------------------------------------------------------------------
module wgm_cell (
  input  logic               clk,
  input  logic               rst,
  input  wgm_pkg::cell_ctl_t ctl,
  input  logic               seed,       // high only for position zero
  input  logic               wr_en,
  input  logic [7:0]         wr_char,
  input  logic               carry_in,   // star closure from the left
  input  logic               adv_in,     // byte match from the left
  output logic               carry_out,
  output logic               adv_out,
  output logic               closed      // position active after closure
);
  import wgm_pkg::*;

  logic [7:0] pat;
  logic       valid;
  logic       raw;
  logic       is_star;
  logic       hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pat <= wr_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= 1'b0;
    end else if (wr_en) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      raw <= seed;
    end else if (ctl.step) begin
      // a star keeps its own position, a match arrives from the left
      raw <= carry_out | adv_in;
    end
  end

  assign closed    = raw | carry_in;
  assign is_star   = valid & (pat == CHAR_ANY_RUN);
  assign hit       = (pat == CHAR_ANY_ONE) | (pat == ctl.text_char);
  assign carry_out = closed & is_star;
  assign adv_out   = closed & valid & ~is_star & hit;

endmodule

@@ rtl/wgm_out_queue.sv @@
// ----------------------------------------------------------------------------
// wgm_out_queue - two-word result buffer
// Output register plus skid word, so the input side keeps running while a
// result waits at the output.
// ----------------------------------------------------------------------------
module wgm_out_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wgm_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output wgm_pkg::result_t out_data
);
  import wgm_pkg::*;

  logic    head_v;
  logic    skid_v;
  result_t head;
  result_t skid;
  logic    pop;

  assign pop = head_v & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_v <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_v) begin
          head   <= skid;
          skid_v <= 1'b0;
          // push cannot occur while the skid word is held
        end else if (push) begin
          head <= push_data;
        end else begin
          head_v <= 1'b0;
        end
      end else if (push) begin
        if (head_v) begin
          skid   <= push_data;
          skid_v <= 1'b1;
        end else begin
          head   <= push_data;
          head_v <= 1'b1;
        end
      end
    end
  end

  assign full      = skid_v;
  assign out_valid = head_v;
  assign out_data  = head;

endmodule

@@ rtl/wildcard_glob_matcher_top.sv @@
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_top - streaming glob matcher ('?' and '*')
// A chain of pattern cells tracks every active pattern position at once and
// updates them all for each text byte.
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ----------------------------------------
//  s_*      in   s_tvalid/s_tready  s_tuser[1:0] command, s_tdata[7:0] char
//  m_*      out  m_tvalid/m_tready  m_tdata[0] matched, [1] pattern_overflow
//
//  One word per cycle on the input while s_tready is high, every command; end
//  of text registers its result in the output register when that is free,
//  otherwise in the skid word behind the word still waiting there.
//  The set of active positions closes over '*' runs through the cell chain,
//  a combinational ripple from cell zero to the last cell.
//  Reset empties the pattern and clears the overflow flag; no clearing pass.
//  s_tready drops only while two results wait at a stalled output.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_value
  input  logic [1:0] s_tuser,   // [1:0] command
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);
  import wgm_pkg::*;

  logic             accept;
  cmd_t             cmd;
  cell_ctl_t        ctl;
  logic [LEN_W-1:0] len;
  logic             overflow;
  logic             raw_end;
  logic             q_full;
  logic             push;
  result_t          push_data;
  result_t          q_data;

  logic [MAX_PATTERN-1:0] carry;
  logic [MAX_PATTERN-1:0] adv;
  logic [MAX_PATTERN:0]   closed_all;

  assign accept = s_tvalid & s_tready;
  assign cmd    = cmd_t'(s_tuser);

  // Decode the command into the cell broadcast word.
  always_comb begin
    ctl           = '0;
    ctl.text_char = s_tdata;
    if (accept) begin
      unique case (cmd)
        CMD_CLEAR: begin
          ctl.clear   = 1'b1;
          ctl.restart = 1'b1;
        end
        CMD_APPEND: ctl.restart = 1'b1;
        CMD_TEXT:   ctl.step    = 1'b1;
        CMD_END:    ctl.restart = 1'b1;
        default:    ctl         = '0;
      endcase
    end
  end

  // Pattern length and overflow: append writes the cell at index len.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      len      <= '0;
      overflow <= 1'b0;
    end else if (accept && cmd == CMD_APPEND) begin
      if (len < LEN_W'(MAX_PATTERN)) begin
        len <= len + LEN_W'(1);
      end else begin
        overflow <= 1'b1;  // drop the byte, flag until next clear
      end
    end
  end

  // Cell chain: position i lives in cell i; position MAX_PATTERN is raw_end.
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic wr_en;
    logic c_in;
    logic a_in;
    assign wr_en = accept && (cmd == CMD_APPEND) && (len == LEN_W'(i));
    if (i == 0) begin : g_head
      assign c_in = 1'b0;
      assign a_in = 1'b0;
    end else begin : g_body
      assign c_in = carry[i-1];
      assign a_in = adv[i-1];
    end
    wgm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .seed      ((i == 0) ? 1'b1 : 1'b0),
      .wr_en     (wr_en),
      .wr_char   (s_tdata),
      .carry_in  (c_in),
      .adv_in    (a_in),
      .carry_out (carry[i]),
      .adv_out   (adv[i]),
      .closed    (closed_all[i])
    );
  end

  // Final position, reached only by a match in the last cell.
  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      raw_end <= 1'b0;
    end else if (ctl.step) begin
      raw_end <= adv[MAX_PATTERN-1];
    end
  end
  assign closed_all[MAX_PATTERN] = raw_end | carry[MAX_PATTERN-1];

  // End of text: report whether the position past the pattern is active.
  assign push                       = accept && (cmd == CMD_END);
  assign push_data.matched          = closed_all[len];
  assign push_data.pattern_overflow = overflow;

  wgm_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (q_data)
  );

  assign s_tready = ~q_full;
  assign m_tdata  = {6'b0, q_data.pattern_overflow, q_data.matched};

endmodule

@@ rtl/wgm_checker.sv @@
// ----------------------------------------------------------------------------
// wgm_checker - port-level checks for the glob matcher
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module wgm_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [1:0] s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);
  import wgm_pkg::*;

  logic acc;
  logic acc_end;
  logic acc_clear;

  assign acc       = s_tvalid & s_tready;
  assign acc_end   = acc & (s_tuser == CMD_END);
  assign acc_clear = acc & (s_tuser == CMD_CLEAR);

  // Hold a stalled result word.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  // A word other than end of text with nothing pending gives no result.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    acc && !acc_end && !m_tvalid |=> !m_tvalid)
    else $error("result without end of text");

  // End of text delivers a result in the next cycle.
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    acc_end |=> m_tvalid)
    else $error("end of text gave no result");

  // Empty pattern matches empty text, without overflow.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (acc_clear && !m_tvalid) ##1 acc_end |=> m_tvalid && m_tdata[1:0] == 2'b01)
    else $error("empty pattern did not match empty text");

endmodule

bind wildcard_glob_matcher_top wgm_checker u_wgm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ tb/sv/tb_wildcard_glob_matcher_top.sv @@
// ----------------------------------------------------------------------------
// tb_wildcard_glob_matcher_top - self-checking bench for the glob matcher
// Streams pattern and text words into the matcher and tracks the expected
// verdict of every end of text. Each returned word is compared against the
// oldest pending verdict. Both ends pause at random in several mixes.
// ----------------------------------------------------------------------------
module tb_wildcard_glob_matcher_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wgm_pkg::*;

  // Generous bound for a run of about 1100 words, even in the slowest mix.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_WORDS   = 340;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;  // 'a'

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] char_value
  logic [1:0] s_tuser = CMD_CLEAR;  // [1:0] command
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [0] matched, [1] pattern_overflow, [7:2] zero

  wildcard_glob_matcher_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle rates in percent for the sending and receiving side.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned words_sent    = 0;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;

  // --------------------------------------------------------------------------
  // Expected matcher state: pattern bytes, length, active position set and
  // the overflow flag. Verdicts wait in order until the matcher returns them.
  // --------------------------------------------------------------------------
  logic [7:0]           glob_pattern [MAX_PATTERN];
  int unsigned          glob_len = 0;
  logic [MAX_PATTERN:0] glob_live  = {{MAX_PATTERN{1'b0}}, 1'b1};
  logic                 glob_ovf   = 1'b0;
  result_t              verdicts_due [$];

  // Propagate every active '*' to the position after it, left to right so a
  // run of stars opens up in one pass.
  function automatic logic [MAX_PATTERN:0] open_star_runs(logic [MAX_PATTERN:0] set);
    for (int i = 0; i < glob_len; i++) begin
      if (set[i] && glob_pattern[i] == CHAR_ANY_RUN) set[i + 1] = 1'b1;
    end
    return set;
  endfunction

  function automatic void reseed_positions();
    glob_live = open_star_runs({{MAX_PATTERN{1'b0}}, 1'b1});
  endfunction

  // Advance the expected state by one accepted word; end of text queues a verdict.
  function automatic void glob_advance(cmd_t cmd, logic [7:0] ch);
    logic [MAX_PATTERN:0] nxt;
    result_t              verdict;
    case (cmd)
      CMD_CLEAR: begin
        glob_len = 0;
        glob_ovf = 1'b0;
        reseed_positions();
      end
      CMD_APPEND: begin
        if (glob_len < MAX_PATTERN) begin
          glob_pattern[glob_len] = ch;
          glob_len++;
        end else begin
          glob_ovf = 1'b1;
        end
        reseed_positions();
      end
      CMD_TEXT: begin
        nxt = '0;
        for (int i = 0; i < glob_len; i++) begin
          if (glob_live[i]) begin
            if (glob_pattern[i] == CHAR_ANY_RUN) nxt[i] = 1'b1;
            else if (glob_pattern[i] == CHAR_ANY_ONE || glob_pattern[i] == ch)
              nxt[i + 1] = 1'b1;
          end
        end
        glob_live = open_star_runs(nxt);
      end
      default: begin
        verdict.matched          = glob_live[glob_len];
        verdict.pattern_overflow = glob_ovf;
        verdicts_due = {verdicts_due, verdict};
        reseed_positions();
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Send one word: idle for a random number of cycles, present the word at
  // the falling edge and hold it until an edge sees s_tready. Valid stays
  // high afterwards so back-to-back words flow without a bubble.
  // --------------------------------------------------------------------------
  task automatic send_word(cmd_t cmd, logic [7:0] ch);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= ch;
    do @(posedge clk); while (!s_tready);
    glob_advance(cmd, ch);
    words_sent++;
  endtask

  // Receiver: drop tready at random, decided at the falling edge.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check each returned word against the oldest pending verdict.
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (verdicts_due.size() == 0) begin
        $error("unexpected result word %02h", m_tdata);
        fail_count++;
      end else begin
        want = verdicts_due.pop_front();
        if (m_tdata[0] !== want.matched) begin
          $error("matched: expected %0b, got %0b", want.matched, m_tdata[0]);
          fail_count++;
        end
        if (m_tdata[1] !== want.pattern_overflow) begin
          $error("pattern_overflow: expected %0b, got %0b",
                 want.pattern_overflow, m_tdata[1]);
          fail_count++;
        end
        if (m_tdata[7:2] !== 6'd0) begin
          $error("tdata pad: expected 0, got %0h", m_tdata[7:2]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Empty pattern against empty and non-empty text.
  task automatic test_empty_text();
    send_word(CMD_END, 8'h00);
    send_word(CMD_TEXT, CHAR_LOWER_A);
    send_word(CMD_END, 8'hFF);
  endtask

  // '?' takes any one byte, '*' any run; an empty text misses a literal.
  task automatic test_wildcards();
    send_word(CMD_CLEAR, 8'hFF);
    send_word(CMD_APPEND, CHAR_LOWER_A);
    send_word(CMD_APPEND, CHAR_ANY_ONE);
    send_word(CMD_APPEND, CHAR_ANY_RUN);
    send_word(CMD_TEXT, CHAR_LOWER_A);
    send_word(CMD_TEXT, 8'h80);
    send_word(CMD_TEXT, CHAR_LOWER_A);
    send_word(CMD_END, 8'h00);
    send_word(CMD_END, 8'h00);
  endtask

  // A '*' byte in the text is plain data; the pattern star still spans.
  task automatic test_literal_star();
    send_word(CMD_CLEAR, 8'h00);
    send_word(CMD_APPEND, CHAR_ANY_RUN);
    send_word(CMD_APPEND, CHAR_ANY_RUN);
    send_word(CMD_END, 8'h00);
    send_word(CMD_APPEND, CHAR_ANY_RUN);
    send_word(CMD_TEXT, CHAR_ANY_RUN);
    send_word(CMD_TEXT, CHAR_ANY_RUN);
    send_word(CMD_END, 8'h00);
  endtask

  // Appending mid-text abandons the text and restarts at position zero.
  task automatic test_append_mid_text();
    send_word(CMD_CLEAR, 8'h00);
    send_word(CMD_APPEND, CHAR_LOWER_A);
    send_word(CMD_TEXT, CHAR_LOWER_A);
    send_word(CMD_APPEND, CHAR_LOWER_A + 8'd1);
    send_word(CMD_TEXT, CHAR_LOWER_A);
    send_word(CMD_TEXT, CHAR_LOWER_A + 8'd1);
    send_word(CMD_END, 8'h00);
  endtask

  // Bytes 0x00 and 0xFF as literals in pattern and text.
  task automatic test_field_extremes();
    send_word(CMD_CLEAR, 8'hFF);
    send_word(CMD_APPEND, 8'h00);
    send_word(CMD_APPEND, 8'hFF);
    send_word(CMD_TEXT, 8'h00);
    send_word(CMD_TEXT, 8'hFF);
    send_word(CMD_END, 8'hFF);
    send_word(CMD_TEXT, 8'hFF);
    send_word(CMD_TEXT, 8'h00);
    send_word(CMD_END, 8'h00);
  endtask

  // Fill the pattern to capacity, overflow it, then clear the flag.
  task automatic test_pattern_overflow();
    send_word(CMD_CLEAR, 8'h00);
    repeat (MAX_PATTERN - 1) send_word(CMD_APPEND, CHAR_ANY_RUN);
    send_word(CMD_APPEND, 8'h7A);
    send_word(CMD_TEXT, 8'h7A);
    send_word(CMD_END, 8'h00);
    send_word(CMD_APPEND, 8'h71);  // dropped
    send_word(CMD_TEXT, 8'h7A);
    send_word(CMD_END, 8'h00);
    send_word(CMD_CLEAR, 8'h00);
    send_word(CMD_END, 8'h00);
  endtask

  // --------------------------------------------------------------------------
  // Random traffic
  // --------------------------------------------------------------------------

  // Small alphabet so literals line up often, plus wildcards and any byte.
  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(0, 9))
      0, 1:    return CHAR_ANY_RUN;
      2:       return CHAR_ANY_ONE;
      3:       return 8'($urandom_range(0, 255));
      default: return CHAR_LOWER_A + 8'($urandom_range(0, 2));
    endcase
  endfunction

  // Build a pattern, then run a few texts against it: half of them derived
  // from the pattern so matches are common, the rest drawn freely.
  task automatic run_glob_sequence();
    logic [7:0] pat [$];
    logic [7:0] sym;
    int         plen;
    int         tlen;
    if ($urandom_range(0, 9) != 0) send_word(CMD_CLEAR, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 14) == 0) plen = $urandom_range(MAX_PATTERN - 4, MAX_PATTERN + 3);
    else plen = $urandom_range(0, 6);
    repeat (plen) begin
      sym = pick_symbol();
      pat = {pat, sym};
      send_word(CMD_APPEND, sym);
    end
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 1) == 1) begin
        foreach (pat[k]) begin
          if (pat[k] == CHAR_ANY_RUN) begin
            repeat ($urandom_range(0, 2)) send_word(CMD_TEXT, pick_symbol());
          end else if (pat[k] == CHAR_ANY_ONE) begin
            send_word(CMD_TEXT, 8'($urandom_range(0, 255)));
          end else if ($urandom_range(0, 19) == 0) begin
            send_word(CMD_TEXT, pick_symbol());  // occasional near miss
          end else begin
            send_word(CMD_TEXT, pat[k]);
          end
        end
      end else begin
        tlen = $urandom_range(0, 8);
        repeat (tlen) send_word(CMD_TEXT, pick_symbol());
      end
      send_word(CMD_END, 8'($urandom_range(0, 255)));
    end
    // Noise: arbitrary commands with arbitrary bytes.
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4))
        send_word(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_phase(int unsigned send_pct, int unsigned recv_pct);
    int unsigned stop_at;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = words_sent + PHASE_WORDS;
    while (words_sent < stop_at) run_glob_sequence();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_text();
    test_wildcards();
    test_literal_star();
    test_append_mid_text();
    test_field_extremes();
    test_pattern_overflow();

    test_random_phase(28, 56);
    test_random_phase(56, 28);
    test_random_phase(0, 0);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
